[hdl/hnm_pkg.sv]
package hnm_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // magnitude and accumulator widths
    localparam int MAG_W  = 49;
    localparam int NORM_W = 22;
    localparam int SQ_W   = 2 * NORM_W;
    localparam int Q_W    = SQ_W + 2;
    localparam int CMP_W  = 62;

    // 255^2, and 2*65535 for the z term
    localparam logic [MUL_B_W-1:0] K_BYTE_SQ = 22'd65025;
    localparam logic [MUL_B_W-1:0] K_Z_MULT  = 22'd131070;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;
    localparam logic [1:0] REG_GRID_SPACING = 2'd3;

    // component selectors
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_WR,
        ST_MULX,
        ST_MULY,
        ST_MULZ,
        ST_GETZ,
        ST_SHIFT,
        ST_SQY,
        ST_SQZ,
        ST_SUM,
        ST_C2,
        ST_CC,
        ST_TT,
        ST_TQ,
        ST_CMP,
        ST_OUT
    } t_state;

endpackage

[hdl/hnm_mul.sv]
module hnm_mul
    import hnm_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[hdl/hnm_line_store.sv]
module hnm_line_store
    import hnm_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/heightmap_normal_map.sv]
// Height map to normal map, forward differences.
// Input: height samples (16-bit unsigned, s_axis_tdata) in raster order.
// Output: one normal per pixel except the last row and column, as bytes x, y, z
// on m_axis_tdata, with m_axis_tlast marking the final normal of the image.
// Configuration: write row_width, row_count, height_scale, grid_spacing through
// i_cfg_wr_en / i_cfg_index / i_cfg_data while the block is idle.
// A transfer that yields no normal runs ST_IDLE, ST_RD0, ST_RD1, ST_WR and
// returns to ST_IDLE; a zero-length normal skips the search. One shared 48x22
// multiplier forms the slope products, the squares and every step of an
// eight-step binary search per component, and the normalizing shift moves one
// bit per cycle.
// s_axis_tready is high only between items.
// A finished normal sits in the output register; the next sample is taken while
// it waits. If the receiver stalls, the following normal waits in ST_OUT until
// the output register frees.
// Reset (synchronous, active low) restores the default sizes and scales and
// starts a new image at row 0, column 0. The line store is not cleared; the
// first row of each image refills it before it is read.
module heightmap_normal_map
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] height_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] normal_x, [15:8] normal_y, [23:16] normal_z
    output logic        m_axis_tlast    // end_of_image
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    // configuration
    logic [12:0] r_row_width;
    logic [15:0] r_row_count;
    logic [31:0] r_height_scale;
    logic [31:0] r_grid_spacing;

    // position
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [CW-1:0] r_cur;
    logic          r_emit;
    logic          r_eoi;

    // pixel data
    logic [15:0] r_x;
    logic [15:0] r_z0;
    logic [15:0] r_z1;

    // datapath
    logic [MAG_W-1:0] r_mx, r_my, r_mz;
    logic             r_xneg, r_yneg;
    logic [SQ_W-1:0]  r_sqx, r_sqy, r_sqz;
    logic [Q_W-1:0]   r_q;
    logic [CMP_W-1:0] r_c2;
    logic [1:0]       r_comp;
    logic [7:0]       r_lo, r_hi, r_k;
    logic [7:0]       r_nx, r_ny, r_nz;

    // output register
    logic        r_oval;
    logic [23:0] r_odata;
    logic        r_olast;

    t_state r_state, n_state;

    // shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic               mem_we;
    logic [AW-1:0]      mem_raddr;
    logic [15:0]        mem_rdata;

    hnm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    hnm_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cur[AW-1:0]),
        .i_wdata (r_x),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // effective sizes
    logic [CW-1:0] w_eff;
    logic [15:0]   h_eff;

    always_comb begin
        if (r_row_width < 13'd2) begin
            w_eff = CW'(2);
        end else if (32'(r_row_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_row_width);
        end
        h_eff = (r_row_count < 16'd2) ? 16'd2 : r_row_count;
    end

    // position before and after this sample
    logic [CW-1:0] col_a;
    logic [15:0]   row_a;
    logic [CW:0]   col_inc;
    logic [16:0]   row_inc;
    logic [CW-1:0] n_col;
    logic [15:0]   n_row;
    logic          pix_emit, pix_eoi;

    always_comb begin
        col_a = r_col;
        row_a = r_row;
        if (r_col >= w_eff) begin
            col_a = '0;
            row_a = r_row + 16'd1;
        end
        if (row_a >= h_eff) begin
            row_a = '0;
        end
        col_inc  = (CW + 1)'(col_a) + (CW + 1)'(1);
        pix_emit = (row_a != 16'd0) && (col_inc < (CW + 1)'(w_eff));
        pix_eoi  = (row_a == h_eff - 16'd1) && (col_a == w_eff - CW'(2));
        n_col    = CW'(col_inc);
        n_row    = row_a;
        row_inc  = 17'(row_a) + 17'd1;
        if (col_inc >= (CW + 1)'(w_eff)) begin
            n_col = '0;
            n_row = (row_inc >= 17'(h_eff)) ? 16'd0 : row_inc[15:0];
        end
    end

    // slopes
    logic [15:0] dx, dy;
    assign dx = (r_z1 > r_z0) ? (r_z1 - r_z0) : (r_z0 - r_z1);
    assign dy = (r_x > r_z0) ? (r_x - r_z0) : (r_z0 - r_x);

    // binary search step
    logic [8:0] k_sum;
    logic [7:0] k_mid;
    logic [8:0] k_dbl;
    logic [7:0] t_val;
    logic       neg_cur;
    logic       lower_half;
    logic       step_ok;
    logic [7:0] n_lo, n_hi;

    always_comb begin
        k_sum = 9'(r_lo) + 9'(r_hi) + 9'd1;
        k_mid = k_sum[8:1];
        k_dbl = {k_mid, 1'b0};
        t_val = (k_mid <= 8'd127) ? 8'(9'd255 - k_dbl) : 8'(k_dbl - 9'd255);
        case (r_comp)
            COMP_X:  neg_cur = r_xneg && (r_mx != '0);
            COMP_Y:  neg_cur = r_yneg && (r_my != '0);
            default: neg_cur = 1'b0;
        endcase
        lower_half = (r_k <= 8'd127);
        if (lower_half) begin
            step_ok = !neg_cur || (mul_p[CMP_W-1:0] >= r_c2);
        end else begin
            step_ok = !neg_cur && (mul_p[CMP_W-1:0] <= r_c2);
        end
        n_lo = step_ok ? r_k : r_lo;
        n_hi = step_ok ? r_hi : (r_k - 8'd1);
    end

    logic out_free;
    assign out_free = !r_oval || m_axis_tready;

    // sequencer: next state, operand select, memory control
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_raddr = r_cur[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_RD0;
                end
            end
            ST_RD0: n_state = ST_RD1;
            ST_RD1: begin
                mem_raddr = r_cur[AW-1:0] + AW'(1);
                n_state   = ST_WR;
            end
            ST_WR: begin
                mem_we  = 1'b1;
                n_state = r_emit ? ST_MULX : ST_IDLE;
            end
            ST_MULX: begin
                mul_a   = MUL_A_W'(r_height_scale);
                mul_b   = MUL_B_W'(dx);
                n_state = ST_MULY;
            end
            ST_MULY: begin
                mul_a   = MUL_A_W'(r_height_scale);
                mul_b   = MUL_B_W'(dy);
                n_state = ST_MULZ;
            end
            ST_MULZ: begin
                mul_a   = MUL_A_W'(r_grid_spacing);
                mul_b   = K_Z_MULT;
                n_state = ST_GETZ;
            end
            ST_GETZ: n_state = ST_SHIFT;
            ST_SHIFT: begin
                if (!(|{r_mx[MAG_W-1:NORM_W], r_my[MAG_W-1:NORM_W], r_mz[MAG_W-1:NORM_W]})) begin
                    mul_a   = MUL_A_W'(r_mx[NORM_W-1:0]);
                    mul_b   = r_mx[NORM_W-1:0];
                    n_state = ST_SQY;
                end
            end
            ST_SQY: begin
                mul_a   = MUL_A_W'(r_my[NORM_W-1:0]);
                mul_b   = r_my[NORM_W-1:0];
                n_state = ST_SQZ;
            end
            ST_SQZ: begin
                mul_a   = MUL_A_W'(r_mz[NORM_W-1:0]);
                mul_b   = r_mz[NORM_W-1:0];
                n_state = ST_SUM;
            end
            ST_SUM: n_state = ST_C2;
            ST_C2: begin
                case (r_comp)
                    COMP_X:  mul_a = MUL_A_W'(r_sqx);
                    COMP_Y:  mul_a = MUL_A_W'(r_sqy);
                    default: mul_a = MUL_A_W'(r_sqz);
                endcase
                mul_b   = K_BYTE_SQ;
                n_state = (r_q == '0) ? ST_OUT : ST_CC;
            end
            ST_CC: n_state = ST_TT;
            ST_TT: begin
                mul_a   = MUL_A_W'(t_val);
                mul_b   = MUL_B_W'(t_val);
                n_state = ST_TQ;
            end
            ST_TQ: begin
                mul_a   = MUL_A_W'(r_q);
                mul_b   = MUL_B_W'(mul_p[15:0]);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (n_lo != n_hi) begin
                    n_state = ST_TT;
                end else if (r_comp == COMP_Z) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_C2;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= 13'd4096;
            r_row_count    <= 16'd4096;
            r_height_scale <= 32'd65536;
            r_grid_spacing <= 32'd65536;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_ROW_WIDTH:    r_row_width    <= i_cfg_data[12:0];
                    REG_ROW_COUNT:    r_row_count    <= i_cfg_data[15:0];
                    REG_HEIGHT_SCALE: r_height_scale <= i_cfg_data;
                    REG_GRID_SPACING: r_grid_spacing <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && s_axis_tvalid) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x    <= s_axis_tdata;
                r_cur  <= col_a;
                r_emit <= pix_emit;
                r_eoi  <= pix_eoi;
            end
            ST_RD1: r_z0 <= mem_rdata;
            ST_WR:  r_z1 <= mem_rdata;
            ST_MULX: begin
                r_xneg <= r_z1 > r_z0;
                r_yneg <= r_x > r_z0;
            end
            ST_MULY: r_mx <= mul_p[MAG_W-1:0];
            ST_MULZ: r_my <= mul_p[MAG_W-1:0];
            ST_GETZ: r_mz <= mul_p[MAG_W-1:0];
            ST_SHIFT: begin
                // drop one low bit from all three until each fits in NORM_W bits
                if (|{r_mx[MAG_W-1:NORM_W], r_my[MAG_W-1:NORM_W], r_mz[MAG_W-1:NORM_W]}) begin
                    r_mx <= r_mx >> 1;
                    r_my <= r_my >> 1;
                    r_mz <= r_mz >> 1;
                end
            end
            ST_SQY: r_sqx <= mul_p[SQ_W-1:0];
            ST_SQZ: r_sqy <= mul_p[SQ_W-1:0];
            ST_SUM: begin
                r_sqz  <= mul_p[SQ_W-1:0];
                r_q    <= Q_W'(r_sqx) + Q_W'(r_sqy) + Q_W'(mul_p[SQ_W-1:0]);
                r_comp <= COMP_X;
            end
            ST_C2: begin
                r_lo <= 8'd0;
                r_hi <= 8'd255;
                if (r_q == '0) begin
                    r_nx <= 8'd127;
                    r_ny <= 8'd127;
                    r_nz <= 8'd255;
                end
            end
            ST_CC: r_c2 <= mul_p[CMP_W-1:0];
            ST_TT: r_k  <= k_mid;
            ST_CMP: begin
                r_lo <= n_lo;
                r_hi <= n_hi;
                if (n_lo == n_hi) begin
                    case (r_comp)
                        COMP_X:  r_nx <= n_lo;
                        COMP_Y:  r_ny <= n_lo;
                        default: r_nz <= n_lo;
                    endcase
                    r_comp <= r_comp + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // output register: load a finished normal, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_oval <= 1'b1;
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_odata <= {r_nz, r_ny, r_nx};
            r_olast <= r_eoi;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

[dv/heightmap_normal_map_tb.sv]
`timescale 1ns / 1ps

module heightmap_normal_map_tb;
    import hnm_pkg::*;

    localparam int MAX_W      = 4096;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] height_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] normal_x, [15:8] normal_y, [23:16] normal_z
    logic        m_axis_tlast;   // end_of_image

    heightmap_normal_map u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct packed {
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
        logic       eoi;
    } t_normal;

    // shadow copy of the block's configuration and raster position
    logic [12:0] cfg_width;
    logic [15:0] cfg_rows;
    logic [31:0] cfg_scale;
    logic [31:0] cfg_spacing;
    logic [15:0] line_buf [MAX_W];
    int unsigned col_pos;
    int unsigned row_pos;

    t_normal     normals_due [$];
    int          err_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold;
    longint      cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // largest k with (2k-255)*sqrt(q) <= 255*c, c signed by neg
    function automatic logic [7:0] unit_to_byte(input bit neg, input logic [63:0] mag,
                                                input logic [63:0] q);
        logic [127:0] c2;
        logic [127:0] t;
        int lo;
        int hi;
        int k;
        bit ok;
        bit cneg;
        c2 = 128'(mag) * mag * 65025;
        cneg = neg && mag != 0;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            k = (lo + hi + 1) / 2;
            if (2 * k < 255) begin
                t = 128'(255 - 2 * k);
                ok = !cneg || (t * t * q >= c2);
            end else begin
                t = 128'(2 * k - 255);
                ok = !cneg && (t * t * q <= c2);
            end
            if (ok) lo = k;
            else hi = k - 1;
        end
        return lo[7:0];
    endfunction

    function automatic t_normal surface_normal(input logic [15:0] z0, input logic [15:0] z1,
                                               input logic [15:0] z2);
        t_normal r;
        bit xneg;
        bit yneg;
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] mz;
        logic [63:0] m;
        logic [63:0] q;
        xneg = z1 > z0;
        yneg = z2 > z0;
        mx = 64'(xneg ? z1 - z0 : z0 - z1) * cfg_scale;
        my = 64'(yneg ? z2 - z0 : z0 - z2) * cfg_scale;
        mz = 64'(cfg_spacing) * 2 * 65535;
        m = mx;
        if (my > m) m = my;
        if (mz > m) m = mz;
        while (m >= 64'(1) << 22) begin
            m = m >> 1;
            mx = mx >> 1;
            my = my >> 1;
            mz = mz >> 1;
        end
        q = mx * mx + my * my + mz * mz;
        r.eoi = 1'b0;
        if (q == 0) begin
            r.nx = 8'd127;
            r.ny = 8'd127;
            r.nz = 8'd255;
        end else begin
            r.nx = unit_to_byte(xneg, mx, q);
            r.ny = unit_to_byte(yneg, my, q);
            r.nz = unit_to_byte(1'b0, mz, q);
        end
        return r;
    endfunction

    // advance the raster position by one sample; queue a normal if one is due
    task automatic take_sample(input logic [15:0] h, input bit typed, input t_normal typed_n);
        int unsigned w;
        int unsigned rows;
        t_normal n;
        w = cfg_width < 2 ? 2 : (cfg_width > MAX_W ? MAX_W : cfg_width);
        rows = cfg_rows < 2 ? 2 : cfg_rows;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= rows) row_pos = 0;
        if (row_pos >= 1 && col_pos + 1 < w) begin
            n = typed ? typed_n
                      : surface_normal(line_buf[12'(col_pos)], line_buf[12'(col_pos + 1)], h);
            n.eoi = (row_pos == rows - 1 && col_pos == w - 2);
            normals_due.push_back(n);
        end
        line_buf[12'(col_pos)] = h;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
        end
    endtask

    task automatic send_sample(input logic [15:0] h, input bit typed, input t_normal typed_n);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        take_sample(h, typed, typed_n);
    endtask

    // drop the input and wait until every expected normal has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_ROW_WIDTH:    cfg_width   = val[12:0];
            REG_ROW_COUNT:    cfg_rows    = val[15:0];
            REG_HEIGHT_SCALE: cfg_scale   = val;
            default:          cfg_spacing = val;
        endcase
    endtask

    // image of w x r with the given scale and spacing, written once the block is empty
    task automatic set_image(input int w, input int r, input logic [31:0] s,
                             input logic [31:0] g);
        wait_drained();
        write_reg(REG_ROW_WIDTH, w);
        write_reg(REG_ROW_COUNT, r);
        write_reg(REG_HEIGHT_SCALE, s);
        write_reg(REG_GRID_SPACING, g);
        i_cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // compare each transfer on the master side with the oldest expectation
    always @(posedge i_clk) begin
        t_normal exp_n;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (normals_due.size() == 0) begin
                $error("unexpected normal %h last %b", m_axis_tdata, m_axis_tlast);
                err_count++;
            end else begin
                exp_n = normals_due.pop_front();
                if (m_axis_tdata[7:0] !== exp_n.nx) begin
                    $error("normal_x exp %0d got %0d", exp_n.nx, m_axis_tdata[7:0]);
                    err_count++;
                end
                if (m_axis_tdata[15:8] !== exp_n.ny) begin
                    $error("normal_y exp %0d got %0d", exp_n.ny, m_axis_tdata[15:8]);
                    err_count++;
                end
                if (m_axis_tdata[23:16] !== exp_n.nz) begin
                    $error("normal_z exp %0d got %0d", exp_n.nz, m_axis_tdata[23:16]);
                    err_count++;
                end
                if (m_axis_tlast !== exp_n.eoi) begin
                    $error("end_of_image exp %0d got %0d", exp_n.eoi, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_CAP) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    typedef struct {
        logic [15:0] h;
        bit          typed;
        t_normal     n;
    } t_row;

    t_row    directed [$];
    t_normal flat;
    int      n_random;
    int      w;
    int      r;
    int      k;

    initial begin
        err_count     = 0;
        recv_hold     = 0;
        send_idle_pct = 35;
        recv_idle_pct = 57;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_width     = 13'd4096;
        cfg_rows      = 16'd4096;
        cfg_scale     = 32'd65536;
        cfg_spacing   = 32'd65536;
        col_pos       = 0;
        row_pos       = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 image, flat and extreme slopes; flat gives straight up.
        // The last three samples are row 0 of the next image.
        set_image(3, 3, 32'd65536, 32'd65536);
        flat = '{nx: 8'd127, ny: 8'd127, nz: 8'd255, eoi: 1'b0};
        directed = '{
            '{16'h0000, 0, flat}, '{16'h0000, 0, flat}, '{16'h0000, 0, flat},
            '{16'h0000, 1, flat}, '{16'hFFFF, 0, flat}, '{16'h8000, 0, flat},
            '{16'hFFFF, 0, flat}, '{16'h0000, 0, flat}, '{16'h5555, 0, flat},
            '{16'hAAAA, 0, flat}, '{16'h0001, 0, flat}, '{16'hFFFE, 0, flat}
        };
        foreach (directed[i]) send_sample(directed[i].h, directed[i].typed, directed[i].n);

        // clamped sizes 0 -> 2, entered at row 1; the fifth sample sees three equal
        // heights with spacing 0, a zero-length normal; the sixth ends the image
        set_image(0, 0, 32'hFFFF_FFFF, 32'd0);
        for (k = 0; k < 6; k++) send_sample(16'h1234, k == 4, flat);

        // extremes of scale and spacing, plus width above the maximum
        set_image(8191, 2, 32'd1, 32'hFFFF_FFFF);
        for (k = 0; k < 6; k++) send_sample(k[0] ? 16'hFFFF : 16'h0000, 0, flat);
        // narrow the row mid-image: the row ends at once and row 1 closes the image
        set_image(6, 2, 32'hFFFF_FFFF, 32'd1);
        for (k = 0; k < 6; k++) send_sample(k[1] ? 16'hFFFF : 16'h0000, 0, flat);

        // random images, three idle phases
        n_random = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 35 : (phase == 1 ? 57 : 0);
            recv_idle_pct = phase == 0 ? 57 : (phase == 1 ? 35 : 0);
            while (n_random < (phase + 1) * 333) begin
                w = $urandom_range(9) == 0 ? $urandom_range(40, 64) : $urandom_range(2, 8);
                r = $urandom_range(2, 5);
                if ($urandom_range(3) == 0) set_image(w, r, $urandom, $urandom);
                else set_image(w, r, $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 18));
                if (phase == 1 && n_random < 400) recv_hold = 3000;
                for (k = 0; k < w * r; k++) begin
                    send_sample($urandom_range(3) == 0 ? 16'($urandom)
                                : 16'(32768 + $urandom_range(0, 600) - 300), 0, flat);
                    n_random++;
                end
                // sender pause until the block has emptied
                if ($urandom_range(7) == 0) begin
                    while (normals_due.size() != 0) begin
                        s_axis_tvalid <= 1'b0;
                        @(posedge i_clk);
                    end
                end
            end
        end

        wait_drained();
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/hnm_pkg.sv
hdl/hnm_mul.sv
hdl/hnm_line_store.sv
hdl/heightmap_normal_map.sv
dv/heightmap_normal_map_tb.sv
